// ----- rtl/firmware_header_crc_checker_unit_defines.svh -----
// Assertion macros for the firmware header CRC checker.
// Each macro expands to one labeled concurrent assertion.
`ifndef FIRMWARE_HEADER_CRC_CHECKER_UNIT_DEFINES_SVH
`define FIRMWARE_HEADER_CRC_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FHCC_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FHCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- rtl/fhcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhcc_pkg
// Types, constants and the byte-wise CRC update shared by the checker blocks.
// ----------------------------------------------------------------------------
package fhcc_pkg;

  localparam logic [3:0]  HDR_LEN   = 4'd8;
  localparam logic [3:0]  CRC_BYTES = 4'd4;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] MODEL_A   = 32'h1057_7050;
  localparam logic [31:0] MODEL_B   = 32'h1057_7040;
  localparam logic [31:0] MODEL_C   = 32'h1057_7000;

  localparam logic [1:0] MODEL_NONE = 2'd0;
  localparam logic [1:0] MODEL_ID_A = 2'd1;
  localparam logic [1:0] MODEL_ID_B = 2'd2;
  localparam logic [1:0] MODEL_ID_C = 2'd3;

  // Result queue geometry.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_CW    = 3;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_BAD_CRC   = 2'd2,
    STATUS_BAD_FLAGS = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_verdict;
    status_t    status;
    logic [1:0] model_id;
    logic       run_end;
  } result_t;

  // Up to two results per processed word.
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

  // Reflected CRC-32 over one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/fhcc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhcc_image_if / fhcc_result_if
// Valid/ready channels for image words in and checker results out.
// ----------------------------------------------------------------------------
interface fhcc_image_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fhcc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_verdict;
  logic [1:0] status;
  logic [1:0] model_id;
  logic       run_end;

  modport source (output valid, output out_byte, output is_verdict, output status,
                  output model_id, output run_end, input ready);
  modport sink (input valid, input out_byte, input is_verdict, input status,
                input model_id, input run_end, output ready);
endinterface

// ----- rtl/fhcc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhcc_core
// Input register, header capture, CRC update and verdict generation.
// ----------------------------------------------------------------------------
module fhcc_core import fhcc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  fhcc_image_if.sink   image,
  input  logic         room,
  output push_t        push
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;

  logic [3:0]  header_count;
  logic [31:0] stored_crc;
  logic [31:0] header_flags;
  logic [31:0] running_crc;

  logic [3:0]  header_count_next;
  logic [31:0] stored_crc_next;
  logic [31:0] header_flags_next;
  logic [31:0] running_crc_next;

  logic        process;
  logic        payload;
  logic [1:0]  model;
  result_t     pay_res;
  result_t     ver_res;

  assign process     = in_valid && room;
  assign image.ready = !in_valid || room;
  assign payload     = (header_count >= HDR_LEN);

  always_comb begin
    stored_crc_next   = stored_crc;
    header_flags_next = header_flags;
    running_crc_next  = running_crc;
    if (header_count < CRC_BYTES) begin
      stored_crc_next = {stored_crc[23:0], in_byte};
    end else begin
      running_crc_next = crc_byte(running_crc, in_byte);
    end
    if (header_count >= CRC_BYTES && !payload) begin
      header_flags_next = {header_flags[23:0], in_byte};
    end
    header_count_next = payload ? header_count : header_count + 4'd1;
  end

  always_comb begin
    if (header_flags_next == MODEL_A) begin
      model = MODEL_ID_A;
    end else if (header_flags_next == MODEL_B) begin
      model = MODEL_ID_B;
    end else if (header_flags_next == MODEL_C) begin
      model = MODEL_ID_C;
    end else begin
      model = MODEL_NONE;
    end

    pay_res            = '0;
    pay_res.out_byte   = in_byte;
    pay_res.status     = STATUS_OK;
    pay_res.run_end    = !in_last;

    ver_res            = '0;
    ver_res.is_verdict = 1'b1;
    ver_res.run_end    = 1'b1;
    if (header_count_next < HDR_LEN) begin
      ver_res.status   = STATUS_SHORT;
      ver_res.model_id = MODEL_NONE;
    end else begin
      ver_res.model_id = model;
      if (running_crc_next != stored_crc_next) begin
        ver_res.status = STATUS_BAD_CRC;
      end else if (model == MODEL_NONE) begin
        ver_res.status = STATUS_BAD_FLAGS;
      end else begin
        ver_res.status = STATUS_OK;
      end
    end

    push        = '0;
    push.first  = payload ? pay_res : ver_res;
    push.second = ver_res;
    if (process) begin
      push.n = {1'b0, payload} + {1'b0, in_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      header_count <= '0;
      stored_crc   <= '0;
      header_flags <= '0;
      running_crc  <= CRC_INIT;
    end else begin
      if (image.ready) begin
        in_valid <= image.valid;
      end
      if (process) begin
        if (in_last) begin
          header_count <= '0;
          stored_crc   <= '0;
          header_flags <= '0;
          running_crc  <= CRC_INIT;
        end else begin
          header_count <= header_count_next;
          stored_crc   <= stored_crc_next;
          header_flags <= header_flags_next;
          running_crc  <= running_crc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (image.ready && image.valid) begin
      in_byte <= image.data_byte;
      in_last <= image.last_byte;
    end
  end

endmodule

// ----- rtl/fhcc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhcc_queue
// Small result queue: takes up to two results a cycle, drives one out.
// ----------------------------------------------------------------------------
module fhcc_queue import fhcc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  push_t          push,
  output logic           room,
  fhcc_result_if.source  result
);

  result_t             mem [Q_DEPTH];
  logic [Q_AW-1:0]     wr_ptr;
  logic [Q_AW-1:0]     rd_ptr;
  logic [Q_CW-1:0]     count;
  logic                pop;
  result_t             head;

  assign room = (count <= Q_CW'(Q_DEPTH - 2));
  assign pop  = (count != '0) && result.ready;
  assign head = mem[rd_ptr];

  assign result.valid      = (count != '0);
  assign result.out_byte   = head.out_byte;
  assign result.is_verdict = head.is_verdict;
  assign result.status     = head.status;
  assign result.model_id   = head.model_id;
  assign result.run_end    = head.run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push.n);
      rd_ptr <= rd_ptr + Q_AW'(pop);
      count  <= count + Q_CW'(push.n) - Q_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + Q_AW'(1)] <= push.second;
    end
  end

endmodule

// ----- rtl/firmware_header_crc_checker_unit.sv -----
`timescale 1ns / 1ps
// Path: input register, then the result queue; a word waits for queue room.
// Throughput: one byte per cycle when the queue has room; a payload byte
//   that is also the last byte yields two results, and the single-result
//   output port sets that pace.
// Reset (rst, synchronous): empties the input register and result queue and
//   restarts header capture with the CRC at all ones.
// ----------------------------------------------------------------------------
// firmware_header_crc_checker_unit
// Strips the eight-byte header of a firmware image, passes payload bytes on
// and ends each image with a verdict on its CRC and model flag word.
// ----------------------------------------------------------------------------
module firmware_header_crc_checker_unit import fhcc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  fhcc_image_if.sink    image,
  fhcc_result_if.source result
);

  // Results of one processed word, and whether the queue can take two more.
  push_t push;
  logic  room;

  // Capture the header, run the CRC, build payload and verdict results.
  fhcc_core u_core (
    .clk   (clk),
    .rst   (rst),
    .image (image),
    .room  (room),
    .push  (push)
  );

  // Hold results until taken downstream; advance one a cycle while ready.
  fhcc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .result (result)
  );

endmodule

// ----- rtl/fhcc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhcc_checker
// Port-level checks on the result channel of the header checker.
// ----------------------------------------------------------------------------
`include "firmware_header_crc_checker_unit_defines.svh"

module fhcc_checker import fhcc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_verdict,
  input logic [1:0] status,
  input logic [1:0] model_id,
  input logic       run_end
);

  logic verdict_word;
  logic payload_word;
  logic short_word;

  assign verdict_word = out_valid && is_verdict;
  assign payload_word = out_valid && !is_verdict;
  assign short_word   = verdict_word && (status == STATUS_SHORT);

  `FHCC_ASSERT_NEXT(a_valid_hold, clk, rst, out_valid && !out_ready, out_valid)
  `FHCC_ASSERT_IMPL(a_verdict_ends, clk, rst, verdict_word, run_end && out_byte == 8'd0)
  `FHCC_ASSERT_IMPL(a_payload_status, clk, rst, payload_word, status == STATUS_OK)
  `FHCC_ASSERT_IMPL(a_payload_model, clk, rst, payload_word, model_id == MODEL_NONE)
  `FHCC_ASSERT_IMPL(a_short_no_model, clk, rst, short_word, model_id == MODEL_NONE)

endmodule

bind firmware_header_crc_checker_unit fhcc_checker u_fhcc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_byte   (result.out_byte),
  .is_verdict (result.is_verdict),
  .status     (result.status),
  .model_id   (result.model_id),
  .run_end    (result.run_end)
);

// ----- tb/sv/fhcc_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhcc_result_checker
// Watches the image and result channels of the header CRC checker, predicts
// the results of each accepted image word and compares them in order.
// ----------------------------------------------------------------------------
module fhcc_result_checker import fhcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  fhcc_image_if       image,
  fhcc_result_if      result,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  // Shadow of the header capture and CRC state.
  logic [3:0]  hdr_seen;
  logic [31:0] hdr_crc;
  logic [31:0] hdr_flags;
  logic [31:0] crc_acc;

  result_t expected_results[$];

  initial pending_count = 0;

  // Reflected CRC-32, one input bit at a time; the top also uses this to
  // build images with a good stored CRC.
  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic predict_image_word(input logic [7:0] b, input logic last);
    logic [3:0] idx;
    logic [1:0] model;
    result_t    r;
    idx = hdr_seen;
    if (idx < CRC_BYTES) begin
      hdr_crc = {hdr_crc[23:0], b};
    end else begin
      crc_acc = crc32_update(crc_acc, b);
    end
    if (idx >= CRC_BYTES && idx < HDR_LEN) begin
      hdr_flags = {hdr_flags[23:0], b};
    end
    if (idx >= HDR_LEN) begin
      r.out_byte   = b;
      r.is_verdict = 1'b0;
      r.status     = STATUS_OK;
      r.model_id   = MODEL_NONE;
      r.run_end    = !last;
      expected_results.push_back(r);
    end else begin
      hdr_seen = idx + 4'd1;
    end
    if (last) begin
      r.out_byte   = 8'h00;
      r.is_verdict = 1'b1;
      r.run_end    = 1'b1;
      model        = MODEL_NONE;
      if (idx + 4'd1 < HDR_LEN) begin
        r.status = STATUS_SHORT;
      end else begin
        if (hdr_flags == MODEL_A) begin
          model = MODEL_ID_A;
        end else if (hdr_flags == MODEL_B) begin
          model = MODEL_ID_B;
        end else if (hdr_flags == MODEL_C) begin
          model = MODEL_ID_C;
        end
        // A bad CRC wins over unknown flags.
        if (crc_acc != hdr_crc) begin
          r.status = STATUS_BAD_CRC;
        end else if (model == MODEL_NONE) begin
          r.status = STATUS_BAD_FLAGS;
        end else begin
          r.status = STATUS_OK;
        end
      end
      r.model_id = model;
      expected_results.push_back(r);
      hdr_seen  = '0;
      hdr_crc   = '0;
      hdr_flags = '0;
      crc_acc   = CRC_INIT;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result_word();
    result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result word: out_byte %0h is_verdict %0b status %0d",
             result.out_byte, result.is_verdict, result.status);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      check_field("out_byte", want.out_byte, result.out_byte);
      check_field("is_verdict", want.is_verdict, result.is_verdict);
      check_field("status", want.status, result.status);
      check_field("model_id", want.model_id, result.model_id);
      check_field("run_end", want.run_end, result.run_end);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hdr_seen   = '0;
      hdr_crc    = '0;
      hdr_flags  = '0;
      crc_acc    = CRC_INIT;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (image.valid && image.ready) begin
        predict_image_word(image.data_byte, image.last_byte);
      end
      if (result.valid && result.ready) begin
        check_result_word();
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds firmware images byte by byte into the header CRC checker, with good
// and bad CRCs, known and unknown flag words and short images, under random
// gaps and result stalls; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module testbench;
  import fhcc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned words_sent = 0;

  // Bytes of the image being sent, header first.
  logic [7:0] image_bytes[$];

  fhcc_image_if  image_ch();
  fhcc_result_if result_ch();

  firmware_header_crc_checker_unit dut (
    .clk    (clk),
    .rst    (rst),
    .image  (image_ch),
    .result (result_ch)
  );

  fhcc_result_checker image_check (
    .clk           (clk),
    .rst           (rst),
    .image         (image_ch),
    .result        (result_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Flag word: mostly a known model, else a near miss or random.
  function automatic logic [31:0] pick_flags();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return MODEL_A;
    if (r < 5) return MODEL_B;
    if (r < 7) return MODEL_C;
    if (r < 8) return MODEL_B ^ (32'h1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  // Payload length: mostly short, a few long images.
  function automatic int pick_payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 16);
    if (r < 95) return $urandom_range(17, 48);
    return $urandom_range(49, 120);
  endfunction

  // Build a full image; fill < 0 means random payload bytes.
  task automatic build_image(input logic [31:0] flags, input int payload_len,
                             input bit good_crc, input int fill);
    logic [31:0] crc;
    logic [31:0] stored;
    logic [7:0]  b;
    logic [7:0]  payload[$];
    image_bytes.delete();
    crc = CRC_INIT;
    // The CRC covers the flag word and the payload, not the stored CRC.
    for (int i = 0; i < 4; i++) begin
      crc = image_check.crc32_update(crc, flags[31 - 8 * i -: 8]);
    end
    for (int i = 0; i < payload_len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      payload.push_back(b);
      crc = image_check.crc32_update(crc, b);
    end
    if (good_crc) begin
      stored = crc;
    end else if ($urandom_range(0, 1) == 0) begin
      stored = crc ^ (32'h1 << $urandom_range(0, 31));
    end else begin
      stored = crc ^ ($urandom | 32'h1);
    end
    for (int i = 0; i < 4; i++) begin
      image_bytes.push_back(stored[31 - 8 * i -: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      image_bytes.push_back(flags[31 - 8 * i -: 8]);
    end
    foreach (payload[i]) begin
      image_bytes.push_back(payload[i]);
    end
  endtask

  // Image that ends inside its header.
  task automatic build_short(input int len, input int fill);
    image_bytes.delete();
    for (int i = 0; i < len; i++) begin
      image_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    end
  endtask

  // Present one word after a gap and hold it until the block takes it.
  task automatic send_word(input logic [7:0] b, input logic last, input int gap);
    repeat (gap) begin
      @(negedge clk);
      image_ch.valid <= 1'b0;
    end
    @(negedge clk);
    image_ch.valid     <= 1'b1;
    image_ch.data_byte <= b;
    image_ch.last_byte <= last;
    do @(posedge clk); while (!image_ch.ready);
    words_sent++;
  endtask

  // Send the built image; a steady image goes with no gaps at all.
  task automatic send_image(input bit steady);
    foreach (image_bytes[i]) begin
      send_word(image_bytes[i], i == image_bytes.size() - 1, steady ? 0 : pick_gap());
    end
  endtask

  // Drop valid and hold off until every expected result has come.
  task automatic drain_results();
    @(negedge clk);
    image_ch.valid <= 1'b0;
    wait (pending_count == 0);
  endtask

  // Result side: bursts of ready broken by stalls, some long stretches
  // with no stall.
  initial begin
    int run_len;
    int stall_len;
    result_ch.ready = 1'b0;
    forever begin
      run_len   = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
      stall_len = pick_gap();
      repeat (run_len) begin
        @(negedge clk);
        result_ch.ready <= 1'b1;
      end
      repeat (stall_len) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int image_no;
    bit steady;
    image_ch.valid     = 1'b0;
    image_ch.data_byte = 8'h00;
    image_ch.last_byte = 1'b0;
    image_no           = 0;

    // Hold reset, then release it at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one-byte image (too short), all zeros.
    build_short(1, 8'h00);
    send_image(1'b0);
    // Header only, model C, good CRC: complete with no payload.
    build_image(MODEL_C, 0, 1'b1, -1);
    send_image(1'b1);
    // Unknown all-zero flags, good CRC, one payload byte of all ones.
    build_image(32'h0000_0000, 1, 1'b1, 8'hFF);
    send_image(1'b0);
    // Last byte at the final header position but one: still too short.
    build_short(7, -1);
    send_image(1'b0);
    drain_results();

    // Random images: well-formed ones with known flags and good CRC, mixed with
    // ones that have a bad CRC, unknown flags or a short length.
    while (words_sent < 1925) begin
      image_no++;
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        build_short($urandom_range(1, 7), -1);
      end else begin
        build_image(pick_flags(), pick_payload_len(), $urandom_range(0, 3) != 0, -1);
      end
      // Pause now and then until the block has caught up.
      if (image_no % 17 == 0) begin
        drain_results();
      end
      send_image(steady);
    end

    // Drain, then keep the clock running for any stray result.
    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fhcc_pkg.sv
rtl/fhcc_if.sv
rtl/fhcc_core.sv
rtl/fhcc_queue.sv
rtl/firmware_header_crc_checker_unit.sv
rtl/fhcc_checker.sv
tb/sv/fhcc_result_checker.sv
tb/sv/testbench.sv
